@@ rtl/ted_pkg.sv @@
package ted_pkg;

	localparam logic [7:0] BOM_BYTE0 = 8'hEF;
	localparam logic [7:0] BOM_BYTE1 = 8'hBB;
	localparam logic [7:0] BOM_BYTE2 = 8'hBF;
	localparam logic [1:0] BOM_LEN   = 2'd3;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] ASCII_END  = 8'h80;

	typedef struct packed {
		logic       is_gbk;
		logic [1:0] skip_len;
	} ted_verdict_t;

	function automatic logic [7:0] bom_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0:    b = BOM_BYTE0;
			2'd1:    b = BOM_BYTE1;
			2'd2:    b = BOM_BYTE2;
			default: b = BOM_BYTE2;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/ted_byte_if.sv @@
interface ted_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

@@ rtl/ted_verdict_if.sv @@
interface ted_verdict_if;
	logic       valid;
	logic       ready;
	logic       is_gbk;
	logic [1:0] skip_len;

	modport source (output valid, output is_gbk, output skip_len, input ready);
	modport sink (input valid, input is_gbk, input skip_len, output ready);
endinterface

@@ rtl/text_encoding_detector_top.sv @@
// text encoding detector
//
// bytes (sink): one file byte per transaction, last_byte marks the final byte.
// verdict (source): one transaction per file, sent after the byte with
// last_byte set; is_gbk = 0 for utf-8, 1 for gbk; skip_len = 3 when the file
// opens with ef bb bf, else 0.
//
// throughput: one byte per cycle while no last byte is held for an unread
// verdict. each byte is captured in an input register and, as it leaves that
// register, folded into the framing state by a single pass of logic, so a new
// byte can be taken every cycle. the verdict is registered as the last byte
// leaves the input register, in the verdict register behind it.
// only the first DETECT_BYTES bytes of a file are examined; later bytes are
// taken and ignored until the last one.
//
// reset clears all framing state and the valid flags of both registers; the
// next byte starts a new file, as does the byte after each last byte.
// stall: while an unread verdict waits, bytes keep flowing; only the next
// last byte holds in the input register until the verdict is taken.
module text_encoding_detector_top #(
	parameter int DETECT_BYTES = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	ted_byte_if.sink      bytes,
	ted_verdict_if.source verdict
);
	import ted_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         advance;
	logic         out_valid_q;
	ted_verdict_t out_q;
	ted_verdict_t scan_verdict;

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.byte_value;
			last_s1 <= bytes.last_byte;
		end
	end

	ted_scan #(
		.DETECT_BYTES(DETECT_BYTES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (advance),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.verdict    (scan_verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			out_q <= scan_verdict;
	end

	assign verdict.valid    = out_valid_q;
	assign verdict.is_gbk   = out_q.is_gbk;
	assign verdict.skip_len = out_q.skip_len;
endmodule

@@ rtl/ted_scan.sv @@
module ted_scan #(
	parameter int DETECT_BYTES = 32768
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            byte_value,
	input  logic                  last_byte,
	output ted_pkg::ted_verdict_t verdict
);
	import ted_pkg::*;

	localparam int CW = $clog2(DETECT_BYTES + 1);

	logic [CW-1:0] count_q;
	logic [1:0]    pending_q;
	logic          seq_bad_q;
	logic          invalid_q;
	logic [1:0]    bom_q;
	logic          bom_broken_q;

	logic [CW-1:0] count_d;
	logic [1:0]    pending_d;
	logic          seq_bad_d;
	logic          invalid_d;
	logic [1:0]    bom_d;
	logic          bom_broken_d;
	logic          in_window;

	assign in_window = count_q < CW'(DETECT_BYTES);

	always_comb begin
		count_d      = count_q;
		pending_d    = pending_q;
		seq_bad_d    = seq_bad_q;
		invalid_d    = invalid_q;
		bom_d        = bom_q;
		bom_broken_d = bom_broken_q;
		if (in_window) begin
			count_d = count_q + CW'(1);
			if (!bom_broken_q && bom_q < BOM_LEN) begin
				if (byte_value == bom_byte(bom_q))
					bom_d = bom_q + 2'd1;
				else
					bom_broken_d = 1'b1;
			end
			if (pending_q != 2'd0) begin
				if ((byte_value & CONT_MASK) != CONT_TAG)
					seq_bad_d = 1'b1;
				pending_d = pending_q - 2'd1;
				if (pending_q == 2'd1) begin
					if (seq_bad_d)
						invalid_d = 1'b1;
					seq_bad_d = 1'b0;
				end
			end else begin
				priority if (byte_value < ASCII_END) begin
				end else if ((byte_value & LEAD2_MASK) == LEAD2_TAG) begin
					if (byte_value < LEAD2_MIN)
						invalid_d = 1'b1;
					else
						pending_d = 2'd1;
				end else if ((byte_value & LEAD3_MASK) == LEAD3_TAG) begin
					pending_d = 2'd2;
				end else if ((byte_value & LEAD4_MASK) == LEAD4_TAG) begin
					if (byte_value > LEAD4_MAX)
						invalid_d = 1'b1;
					else
						pending_d = 2'd3;
				end else begin
					invalid_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (bom_d == BOM_LEN) begin
			verdict.is_gbk   = 1'b0;
			verdict.skip_len = BOM_LEN;
		end else begin
			verdict.is_gbk   = invalid_d;
			verdict.skip_len = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pending_q    <= '0;
			seq_bad_q    <= 1'b0;
			invalid_q    <= 1'b0;
			bom_q        <= '0;
			bom_broken_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				count_q      <= '0;
				pending_q    <= '0;
				seq_bad_q    <= 1'b0;
				invalid_q    <= 1'b0;
				bom_q        <= '0;
				bom_broken_q <= 1'b0;
			end else begin
				count_q      <= count_d;
				pending_q    <= pending_d;
				seq_bad_q    <= seq_bad_d;
				invalid_q    <= invalid_d;
				bom_q        <= bom_d;
				bom_broken_q <= bom_broken_d;
			end
		end
	end
endmodule

@@ rtl/ted_checker.sv @@
module ted_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_is_gbk,
	input logic [1:0] out_skip_len
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_is_gbk) && $stable(out_skip_len))
		else $error("verdict changed while stalled");

	a_skip_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_skip_len == 2'd0 || out_skip_len == 2'd3))
		else $error("bad skip length");

	a_bom_utf8: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_skip_len == 2'd3 |-> !out_is_gbk)
		else $error("bom with gbk verdict");

	a_rise_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("verdict without last byte");
endmodule

bind text_encoding_detector_top ted_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (bytes.valid),
	.in_ready     (bytes.ready),
	.in_last      (bytes.last_byte),
	.out_valid    (verdict.valid),
	.out_ready    (verdict.ready),
	.out_is_gbk   (verdict.is_gbk),
	.out_skip_len (verdict.skip_len)
);

@@ test/ted_verdict_checker.sv @@
module ted_verdict_checker #(
	parameter int DETECT_BYTES = 32768
) (
	input  logic   clk,
	input  logic   arst_n,
	ted_byte_if    bytes,
	ted_verdict_if verdict,
	output int     error_count,
	output int     verdicts_pending,
	output int     verdicts_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	import ted_pkg::*;

	typedef struct packed {
		logic [15:0] taken;
		logic [1:0]  conts_due;
		logic        seq_bad;
		logic        invalid;
		logic [1:0]  mark_hits;
		logic        mark_miss;
	} scan_state_t;

	scan_state_t  scan;
	ted_verdict_t verdicts_due[$];
	ted_verdict_t want;

	function automatic scan_state_t scan_byte(input scan_state_t s, input logic [7:0] b);
		logic [7:0] mark[3];
		mark[0] = BOM_BYTE0;
		mark[1] = BOM_BYTE1;
		mark[2] = BOM_BYTE2;
		if (!s.mark_miss && s.mark_hits < BOM_LEN) begin
			if (b == mark[s.mark_hits])
				s.mark_hits++;
			else
				s.mark_miss = 1'b1;
		end
		if (s.conts_due != 2'd0) begin
			if ((b & CONT_MASK) != CONT_TAG)
				s.seq_bad = 1'b1;
			s.conts_due--;
			if (s.conts_due == 2'd0) begin
				if (s.seq_bad)
					s.invalid = 1'b1;
				s.seq_bad = 1'b0;
			end
		end else if (b < ASCII_END) begin
			// plain ascii
		end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
			if (b < LEAD2_MIN)
				s.invalid = 1'b1;
			else
				s.conts_due = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
			s.conts_due = 2'd2;
		end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
			if (b > LEAD4_MAX)
				s.invalid = 1'b1;
			else
				s.conts_due = 2'd3;
		end else begin
			s.invalid = 1'b1;
		end
		return s;
	endfunction

	function automatic ted_verdict_t file_verdict(input scan_state_t s);
		ted_verdict_t v;
		if (s.mark_hits == BOM_LEN) begin
			v.is_gbk   = 1'b0;
			v.skip_len = BOM_LEN;
		end else begin
			v.is_gbk   = s.invalid;
			v.skip_len = 2'd0;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan = '0;
			verdicts_due.delete();
			error_count = 0;
			verdicts_pending = 0;
			verdicts_checked = 0;
		end else begin
			if (bytes.valid && bytes.ready) begin
				if (scan.taken < DETECT_BYTES) begin
					scan = scan_byte(scan, bytes.byte_value);
					scan.taken++;
				end
				if (bytes.last_byte) begin
					verdicts_due = {verdicts_due, file_verdict(scan)};
					scan = '0;
				end
			end
			if (verdict.valid && verdict.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict transaction with none expected: is_gbk %0d skip_len %0d",
						verdict.is_gbk, verdict.skip_len);
					error_count++;
				end else begin
					want = verdicts_due.pop_front();
					if (verdict.is_gbk !== want.is_gbk) begin
						$error("is_gbk: expected %0d, got %0d", want.is_gbk, verdict.is_gbk);
						error_count++;
					end
					if (verdict.skip_len !== want.skip_len) begin
						$error("skip_len: expected %0d, got %0d", want.skip_len,
							verdict.skip_len);
						error_count++;
					end
					verdicts_checked++;
				end
			end
			verdicts_pending = verdicts_due.size();
		end
	end

endmodule

@@ test/tb_text_encoding_detector_top.sv @@
module tb_text_encoding_detector_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ted_pkg::*;

	localparam int WINDOW       = 16;
	localparam int ITEMS_TARGET = 750;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	ted_byte_if    byte_ch();
	ted_verdict_if verdict_ch();

	int check_errors;
	int verdicts_pending;
	int verdicts_checked;

	int send_idle_pct = 21;
	int recv_idle_pct = 50;
	int hold_req = 0;
	int hold_left;
	int stall_cycles;

	int files_sent = 0;
	int bytes_sent = 0;
	int mark_files = 0;
	int long_files = 0;

	text_encoding_detector_top #(
		.DETECT_BYTES(WINDOW)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.verdict(verdict_ch)
	);

	ted_verdict_checker #(
		.DETECT_BYTES(WINDOW)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.bytes           (byte_ch),
		.verdict         (verdict_ch),
		.error_count     (check_errors),
		.verdicts_pending(verdicts_pending),
		.verdicts_checked(verdicts_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// verdict receiver, with random stalls and a long hold-off on request
	initial begin
		verdict_ch.ready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				verdict_ch.ready = 1'b0;
				hold_left--;
			end else begin
				verdict_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_text_encoding_detector_top: done, errors");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid      = 1'b1;
		byte_ch.byte_value = b;
		byte_ch.last_byte  = last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file(input byte_q_t data);
		foreach (data[i])
			send_byte(data[i], i == data.size() - 1);
		files_sent++;
		bytes_sent += data.size();
		if (data.size() >= 3 && data[0] == BOM_BYTE0 && data[1] == BOM_BYTE1
				&& data[2] == BOM_BYTE2)
			mark_files++;
		if (data.size() > WINDOW)
			long_files++;
	endtask

	task automatic wait_drained();
		byte_ch.valid = 1'b0;
		while (verdicts_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic byte_q_t utf8_char();
		byte_q_t c;
		int n;
		n = $urandom_range(3);
		case (n)
			0: c = {c, 8'($urandom_range(8'h7F, 8'h00))};
			1: c = {c, 8'($urandom_range(8'hDF, LEAD2_MIN))};
			2: c = {c, 8'($urandom_range(8'hEF, LEAD3_TAG))};
			default: c = {c, 8'($urandom_range(LEAD4_MAX, LEAD4_TAG))};
		endcase
		repeat (n) c = {c, CONT_TAG | 8'($urandom_range(63))};
		return c;
	endfunction

	function automatic byte_q_t make_file();
		byte_q_t f;
		byte_q_t c;
		int len;
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			len = $urandom_range(10, 1);
		else if (roll < 95)
			len = $urandom_range(WINDOW + 6, WINDOW - 3);
		else
			len = $urandom_range(4 * WINDOW, WINDOW + 7);
		roll = $urandom_range(99);
		if (roll < 30) begin
			f = {f, BOM_BYTE0, BOM_BYTE1, BOM_BYTE2};
		end else if (roll < 40) begin
			// mark cut short or broken
			f = {f, BOM_BYTE0};
			if ($urandom_range(1))
				f = {f, BOM_BYTE1};
			f = {f, 8'($urandom_range(255))};
		end
		roll = $urandom_range(99);
		while (f.size() < len) begin
			if (roll < 70) begin
				c = utf8_char();
				f = {f, c};
			end else begin
				f = {f, 8'($urandom_range(255))};
			end
		end
		while (f.size() > len)
			void'(f.pop_back());
		if (roll < 70 && $urandom_range(3) == 0)
			f[$urandom_range(f.size() - 1)] = 8'($urandom_range(255));
		return f;
	endfunction

	initial begin
		byte_q_t f;
		bit pressure_done;
		pressure_done = 1'b0;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_value = 8'h00;
		byte_ch.last_byte = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed files
		send_file('{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2, 8'hFF});
		send_file('{8'h00});
		send_file('{8'h7F});
		send_file('{8'hFF});
		send_file('{8'h80});
		send_file('{8'hC1});
		send_file('{8'hF5});
		send_file('{8'hC2, 8'hA9});
		send_file('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
		send_file('{8'hC3, 8'h28});
		send_file('{8'hE2, 8'h82});
		send_file('{BOM_BYTE0, BOM_BYTE1});
		wait_drained();

		while (bytes_sent < ITEMS_TARGET) begin
			if (bytes_sent >= 520) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (bytes_sent >= 280) begin
				if (!pressure_done) begin
					// verdict side held off while short files keep coming
					wait_drained();
					send_idle_pct = 0;
					@(posedge clk);
					hold_req = HOLD_CYCLES;
					@(negedge clk);
					repeat (12) begin
						f.delete();
						repeat ($urandom_range(2, 1)) f = {f, 8'($urandom_range(255))};
						send_file(f);
					end
					wait_drained();
					pressure_done = 1'b1;
				end
				send_idle_pct = 50;
				recv_idle_pct = 21;
			end
			f = make_file();
			send_file(f);
		end

		wait_drained();
		$display("covered %0d files, %0d bytes, %0d verdicts checked, window of %0d bytes",
			files_sent, bytes_sent, verdicts_checked, WINDOW);
		$display("%0d files opened with the byte order mark, %0d ran past the window",
			mark_files, long_files);
		if (check_errors == 0 && verdicts_pending == 0) begin
			$display("tb_text_encoding_detector_top: done, clean");
		end else begin
			$display("tb_text_encoding_detector_top: done, errors");
		end
		$finish;
	end

endmodule
